// File: hdl/ptlpe_pkg.sv
// ptlpe_pkg: shared constants and types of the preorder leaf path emitter
// used by ptlpe_front, ptlpe_job_fifo, ptlpe_back and the top level
`default_nettype none

package ptlpe_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int SYM_W     = 8;
    localparam int LEVEL_W   = 7;
    localparam int PEND_W    = 8;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int PADDR_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [SYM_W-1:0]   NULL_SYM_RESET = 8'd64;
    localparam logic               REG_NULL_SYM = 1'b0;

    typedef enum logic {
        FE_TAKE,
        FE_POP
    } t_fe_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SYM_W-1:0]  data;
    } t_path_wr;

    typedef struct packed {
        logic               ovf;
        logic [LEVEL_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic fifo_empty;
        logic fifo_full;
        logic emitting;
    } t_back_status;

endpackage

`default_nettype wire

// File: hdl/ptlpe_front.sv
// ptlpe_front: preorder parser with pending right-slot stack memory
// depends on ptlpe_pkg; writes the path store held in ptlpe_back
`default_nettype none

module ptlpe_front
    import ptlpe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [SYM_W-1:0]   i_null_sym,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [SYM_W-1:0]   i_sym,
    input  wire logic               i_start,
    input  wire t_back_status       i_status,
    output t_path_wr                o_path_wr,
    output logic                    o_job_push,
    output t_job                    o_job
);

    t_fe_state          r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_nulls, n_nulls;
    logic [LEVEL_W-1:0] r_depth, n_depth;
    logic               r_ovf, n_ovf;
    logic               r_done, n_done;

    logic [PEND_W-1:0]  pend_mem [MAX_DEPTH];
    logic [PEND_W-1:0]  r_pend_q;

    logic [CNT_W-1:0]   e_cnt;
    logic [1:0]         e_nulls;
    logic [LEVEL_W-1:0] e_depth;
    logic               e_ovf;
    logic               e_done;
    logic               is_node;
    logic               emit;
    logic               stall;
    logic               accept;
    logic [LEVEL_W-1:0] d;
    logic [CNT_W-1:0]   cnt_m1;
    logic [PEND_W-1:0]  pop_m1;
    logic               pend_we;
    logic [ADDR_W-1:0]  pend_waddr;
    logic [PEND_W-1:0]  pend_wdata;
    logic               pend_re;
    logic [ADDR_W-1:0]  pend_raddr;

    // parse state as seen after an optional tree start
    assign e_cnt   = i_start ? '0 : r_cnt;
    assign e_nulls = i_start ? 2'd2 : r_nulls;
    assign e_depth = i_start ? '0 : r_depth;
    assign e_ovf   = i_start ? 1'b0 : r_ovf;
    assign e_done  = i_start ? 1'b0 : r_done;

    assign is_node = (i_sym != i_null_sym);
    assign emit    = !e_done && !is_node && (e_nulls == 2'd1);
    assign stall   = is_node ? (!i_status.fifo_empty || i_status.emitting)
                             : (emit && i_status.fifo_full);
    assign o_ready = (r_state == FE_TAKE) && !stall;
    assign accept  = i_valid && o_ready;

    assign d      = (e_depth == LEVEL_MAX) ? LEVEL_MAX : e_depth + LEVEL_W'(1);
    assign cnt_m1 = e_cnt - CNT_W'(1);
    assign pop_m1 = r_pend_q - PEND_W'(1);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_nulls    = r_nulls;
        n_depth    = r_depth;
        n_ovf      = r_ovf;
        n_done     = r_done;
        pend_we    = 1'b0;
        pend_waddr = e_cnt[ADDR_W-1:0];
        pend_wdata = {1'b0, d} + PEND_W'(1);
        pend_re    = 1'b0;
        pend_raddr = cnt_m1[ADDR_W-1:0];
        o_path_wr.we   = 1'b0;
        o_path_wr.addr = ADDR_W'(d - LEVEL_W'(1));
        o_path_wr.data = i_sym;
        o_job_push = 1'b0;
        o_job.ovf  = e_ovf;
        o_job.len  = (e_depth > LEVEL_W'(MAX_DEPTH)) ? LEVEL_W'(MAX_DEPTH) : e_depth;
        unique case (r_state)
            FE_TAKE: begin
                if (accept) begin
                    n_cnt   = e_cnt;
                    n_nulls = e_nulls;
                    n_depth = e_depth;
                    n_ovf   = e_ovf;
                    n_done  = e_done;
                    if (!e_done) begin
                        if (is_node) begin
                            if (d <= LEVEL_W'(MAX_DEPTH)) begin
                                o_path_wr.we = 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (e_cnt < CNT_W'(MAX_DEPTH)) begin
                                pend_we = 1'b1;
                                n_cnt   = e_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_depth = d;
                            n_nulls = 2'd0;
                        end else begin
                            o_job_push = emit;
                            if (e_nulls != 2'd2) begin
                                n_nulls = e_nulls + 2'd1;
                            end
                            if (e_cnt != '0) begin
                                n_cnt   = cnt_m1;
                                pend_re = 1'b1;
                                n_state = FE_POP;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                    end
                end
            end
            FE_POP: begin
                // popped entry holds the slot depth plus one
                if (r_pend_q == '0) begin
                    n_depth = '0;
                end else if (pop_m1[PEND_W-1]) begin
                    n_depth = LEVEL_MAX;
                end else begin
                    n_depth = pop_m1[LEVEL_W-1:0];
                end
                n_state = FE_TAKE;
            end
            default: n_state = FE_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_TAKE;
            r_cnt   <= '0;
            r_nulls <= 2'd2;
            r_depth <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nulls <= n_nulls;
            r_depth <= n_depth;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (pend_re) begin
            r_pend_q <= pend_mem[pend_raddr];
        end
    end

    a_path_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_path_wr.we |-> (i_status.fifo_empty && !i_status.emitting))
        else $error("path store written while a path is being emitted");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DEPTH))
        else $error("pending stack count beyond its depth");

    a_pop_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FE_POP) |-> !o_ready && $past(pend_re))
        else $error("pop cycle without a stack read");

endmodule

`default_nettype wire

// File: hdl/ptlpe_job_fifo.sv
// ptlpe_job_fifo: two-entry queue of leaf emission jobs
// depends on ptlpe_pkg for the job type
`default_nettype none

module ptlpe_job_fifo
    import ptlpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_job   = r_slot[r_rp];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("job queue overrun or underrun");

endmodule

`default_nettype wire

// File: hdl/ptlpe_back.sv
// ptlpe_back: path store memory and leaf-to-root emitter with output register
// depends on ptlpe_pkg; takes jobs from ptlpe_job_fifo
`default_nettype none

module ptlpe_back
    import ptlpe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_path_wr         i_path_wr,
    input  wire logic             i_job_empty,
    input  wire t_job             i_job,
    output logic                  o_job_pop,
    output logic                  o_emitting,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [SYM_W-1:0]      o_sym,
    output logic                  o_last,
    output logic                  o_ovf
);

    logic [SYM_W-1:0]   path_mem [MAX_DEPTH];
    logic [LEVEL_W-1:0] r_cnt, n_cnt;
    logic               r_job_ovf, n_job_ovf;
    logic               r_valid, n_valid;
    logic [SYM_W-1:0]   r_sym;
    logic               r_last;
    logic               r_ovf;
    logic               adv;
    logic               rd_en;
    logic [LEVEL_W-1:0] cnt_m1;

    assign adv        = !r_valid || i_ready;
    assign cnt_m1     = r_cnt - LEVEL_W'(1);
    assign o_emitting = (r_cnt != '0);

    always_comb begin
        n_cnt     = r_cnt;
        n_job_ovf = r_job_ovf;
        o_job_pop = 1'b0;
        rd_en     = 1'b0;
        if (r_cnt == '0) begin
            if (!i_job_empty) begin
                o_job_pop = 1'b1;
                n_cnt     = i_job.len;
                n_job_ovf = i_job.ovf;
            end
        end else if (adv) begin
            rd_en = 1'b1;
            n_cnt = cnt_m1;
        end
        n_valid = adv ? rd_en : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_job_ovf <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_job_ovf <= n_job_ovf;
            r_valid   <= n_valid;
        end
    end

    // path store, leaf end read first
    always_ff @(posedge i_clk) begin
        if (i_path_wr.we) begin
            path_mem[i_path_wr.addr] <= i_path_wr.data;
        end
        if (rd_en) begin
            r_sym  <= path_mem[cnt_m1[ADDR_W-1:0]];
            r_last <= (r_cnt == LEVEL_W'(1));
            r_ovf  <= r_job_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_sym   = r_sym;
    assign o_last  = r_last;
    assign o_ovf   = r_ovf;

    a_no_write_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emitting |-> !i_path_wr.we)
        else $error("path store written during emission");

endmodule

`default_nettype wire

// File: hdl/preorder_tree_leaf_path_emitter.sv
// preorder_tree_leaf_path_emitter: top level, config register and stream ports
// depends on ptlpe_pkg, ptlpe_front, ptlpe_job_fifo, ptlpe_back
//
// port group  direction  contents
// s stream    in         tdata: symbol[7:0]; tuser: starts_tree
// m stream    out        tdata: path_symbol[7:0]; tlast: last_of_path; tuser: depth_overflow
// apb         in/out     null_symbol at byte address 0
//
// a null that pops the pending stack adds a pop state (stack memory read) that blocks input
// a leaf emits its path at one symbol per cycle while the output is ready, leaf first
// node symbols wait while a path is being emitted or queued; nulls keep flowing
// a full job queue holds back a null that ends a leaf; output stalls hold the emitter
// synchronous active-low reset; no clearing pass, memories are read only where written
`default_nettype none

module preorder_tree_leaf_path_emitter
    import ptlpe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // symbol
    input  wire logic [0:0]         i_s_tuser,   // starts_tree
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [7:0]              o_m_tdata,   // path_symbol
    output logic                    o_m_tlast,
    output logic [0:0]              o_m_tuser,   // depth_overflow
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [SYM_W-1:0] r_null_sym;
    logic             reg_sel;
    t_back_status     status;
    t_path_wr         path_wr;
    logic             job_push;
    logic             job_pop;
    t_job             job_in;
    t_job             job_out;
    logic             fifo_empty;
    logic             fifo_full;
    logic             emitting;
    logic             ovf;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_NULL_SYM);
    assign prdata  = reg_sel ? {24'd0, r_null_sym} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_sym <= NULL_SYM_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_null_sym <= pwdata[SYM_W-1:0];
        end
    end

    assign status.fifo_empty = fifo_empty;
    assign status.fifo_full  = fifo_full;
    assign status.emitting   = emitting;

    ptlpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_null_sym (r_null_sym),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_sym      (i_s_tdata),
        .i_start    (i_s_tuser[0]),
        .i_status   (status),
        .o_path_wr  (path_wr),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    ptlpe_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    ptlpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_path_wr   (path_wr),
        .i_job_empty (fifo_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_emitting  (emitting),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_sym       (o_m_tdata),
        .o_last      (o_m_tlast),
        .o_ovf       (ovf)
    );

    assign o_m_tuser = ovf;

endmodule

`default_nettype wire
